>>> src/uvs_pkg.sv
// Types, constants and datapath helpers for the UV-sphere mesh generator.
`timescale 1ns / 1ps

package uvs_pkg;

    localparam int unsigned CNT_W     = 9;
    localparam int unsigned IDX_W     = 17;
    localparam int unsigned CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STACKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 2'd1;

    // request kinds
    localparam logic REQ_VERTEX = 1'b0;
    localparam logic REQ_QUAD   = 1'b1;

    // phase divider: 25 quotient bits, five per stage
    localparam int unsigned QUOT_W     = 25;
    localparam int unsigned DIV_BITS   = 5;
    localparam int unsigned DIV_STAGES = QUOT_W / DIV_BITS;

    // CORDIC: 24 rotations, two per stage
    localparam int unsigned CORDIC_STEPS = 24;
    localparam int unsigned COR_PER      = 2;
    localparam int unsigned COR_STAGES   = CORDIC_STEPS / COR_PER;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd326016435;
    localparam logic [29:0]        HALF_PI_Q29 = 30'd843314857;

    localparam logic signed [31:0] ATAN_Q29 [CORDIC_STEPS] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
        32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
        32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
        32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
        32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
        32'sd512,       32'sd256,       32'sd128,       32'sd64
    };

    localparam logic signed [31:0] ONE_Q14 = 32'sd16384;

    // shade = 0.6 + 0.4 * u, colours = base * shade, all Q0.16
    localparam logic [16:0] SHADE_BASE = 17'd39322;
    localparam logic [31:0] SHADE_SPAN = 32'd26214;
    localparam logic [33:0] RED_Q16    = 34'd19661;
    localparam logic [33:0] GREEN_Q16  = 34'd36045;
    localparam logic [33:0] BLUE_Q16   = 34'd55706;

    typedef struct packed {
        logic             req_type;
        logic [CNT_W-1:0] ring;
        logic [CNT_W-1:0] segment;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
        logic [IDX_W-1:0]   tri0_first;
        logic [IDX_W-1:0]   tri0_second;
        logic [IDX_W-1:0]   tri0_third;
        logic [IDX_W-1:0]   tri1_first;
        logic [IDX_W-1:0]   tri1_second;
        logic [IDX_W-1:0]   tri1_third;
    } out_beat_t;

    // request kind and quad base indices, carried down the pipe
    typedef struct packed {
        logic             req;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
    } side_t;

    // remainder and shifting dividend/quotient word
    typedef struct packed {
        logic [CNT_W-1:0]  rem;
        logic [QUOT_W-1:0] qd;
    } div_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cordic_t;

    typedef struct packed {
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } sincos_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] raw,
                                                     input int unsigned max_cnt);
        if (raw == '0)
            return 9'd1;
        else if (32'(raw) > max_cnt)
            return max_cnt[CNT_W-1:0];
        else
            return raw;
    endfunction

    function automatic div_t div_stage(input div_t cur, input logic [CNT_W-1:0] d);
        logic [CNT_W:0] sh;
        logic           qbit;
        div_t           w;
        w = cur;
        for (int t = 0; t < DIV_BITS; t++)
        begin
            sh   = {w.rem, w.qd[QUOT_W-1]};
            qbit = (sh >= {1'b0, d});
            if (qbit)
                sh = sh - {1'b0, d};
            w.rem = sh[CNT_W-1:0];
            w.qd  = {w.qd[QUOT_W-2:0], qbit};
        end
        return w;
    endfunction

    function automatic cordic_t cordic_stage(input cordic_t cur, input int unsigned stage);
        cordic_t            w;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        int unsigned        k;
        w = cur;
        for (int t = 0; t < COR_PER; t++)
        begin
            k  = stage * COR_PER + t;
            dx = w.y >>> k;
            dy = w.x >>> k;
            if (!w.z[31])
            begin
                w.x = w.x - dx;
                w.y = w.y + dy;
                w.z = w.z - ATAN_Q29[k[4:0]];
            end
            else
            begin
                w.x = w.x + dx;
                w.y = w.y - dy;
                w.z = w.z + ATAN_Q29[k[4:0]];
            end
        end
        return w;
    endfunction

    function automatic sincos_t map_quadrant(input cordic_t c, input logic [1:0] quad);
        sincos_t r;
        case (quad)
            2'd0:
            begin
                r.cos_v = c.x;
                r.sin_v = c.y;
            end
            2'd1:
            begin
                r.cos_v = -c.y;
                r.sin_v = c.x;
            end
            2'd2:
            begin
                r.cos_v = -c.x;
                r.sin_v = -c.y;
            end
            default:
            begin
                r.cos_v = c.y;
                r.sin_v = -c.x;
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
        logic signed [31:0] t;
        t = (v + 32'sd16384) >>> 15;
        if (t > ONE_Q14)
            t = ONE_Q14;
        if (t < -ONE_Q14)
            t = -ONE_Q14;
        return t[15:0];
    endfunction

endpackage

>>> src/uv_sphere_mesh_generator.sv
// UV-sphere mesh generator: vertex position/colour and quad index pipeline.
`timescale 1ns / 1ps
// Throughput: one beat per cycle while in_stall is low; the divider (5 bits/stage) and
// CORDIC (2 rotations/stage) are fully pipelined. in_stall rises only while the output
// skid register holds a beat.
// Reset: valid bits and skid cleared, stacks_reg = 16, slices_reg = 32
// (clamped to MAX_STACKS / MAX_SLICES).

module uv_sphere_mesh_generator #(
    parameter int unsigned MAX_STACKS = 256,
    parameter int unsigned MAX_SLICES = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uvs_pkg::CNT_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  uvs_pkg::in_beat_t                in_beat,
    output logic                             out_valid,
    input  logic                             out_stall,
    output uvs_pkg::out_beat_t               out_beat
);

    import uvs_pkg::*;

    localparam logic [CNT_W-1:0] STACKS_RST = clamp_count(9'd16, MAX_STACKS);
    localparam logic [CNT_W-1:0] SLICES_RST = clamp_count(9'd32, MAX_SLICES);

    // stage map
    localparam int unsigned ST_INIT    = 1;
    localparam int unsigned ST_DIV0    = ST_INIT + 1;
    localparam int unsigned ST_MUL     = ST_DIV0 + DIV_STAGES;
    localparam int unsigned ST_COR0    = ST_MUL + 1;
    localparam int unsigned ST_MAP     = ST_COR0 + COR_STAGES;
    localparam int unsigned ST_PROD    = ST_MAP + 1;
    localparam int unsigned ST_Q14     = ST_PROD + 1;
    localparam int unsigned ST_SHADE   = ST_Q14 + 1;
    localparam int unsigned PIPE_DEPTH = ST_SHADE + 1;

    // configuration
    logic [CNT_W-1:0] stacks_reg, stacks_next;
    logic [CNT_W-1:0] slices_reg, slices_next;

    always_comb
    begin
        stacks_next = stacks_reg;
        slices_next = slices_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_STACKS: stacks_next = clamp_count(cfg_data, MAX_STACKS);
                CFG_SLICES: slices_next = clamp_count(cfg_data, MAX_SLICES);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stacks_reg <= STACKS_RST;
            slices_reg <= SLICES_RST;
        end
        else
        begin
            stacks_reg <= stacks_next;
            slices_reg <= slices_next;
        end
    end

    // pipeline control
    logic                  skid_valid_reg, skid_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  ce;
    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;

    assign ce       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], in_valid};

    // payload registers
    side_t              side_reg  [PIPE_DEPTH];
    side_t              side_next [PIPE_DEPTH];
    logic [CNT_W-1:0]   i0_reg, i0_next;
    logic [CNT_W-1:0]   j0_reg, j0_next;
    div_t               dphi_reg  [DIV_STAGES+1];
    div_t               dphi_next [DIV_STAGES+1];
    div_t               dth_reg   [DIV_STAGES+1];
    div_t               dth_next  [DIV_STAGES+1];
    logic signed [31:0] zphi_reg, zphi_next;
    logic signed [31:0] zth_reg, zth_next;
    logic [1:0]         qphi_reg  [COR_STAGES+1];
    logic [1:0]         qphi_next [COR_STAGES+1];
    logic [1:0]         qth_reg   [COR_STAGES+1];
    logic [1:0]         qth_next  [COR_STAGES+1];
    cordic_t            cphi_reg  [COR_STAGES];
    cordic_t            cphi_next [COR_STAGES];
    cordic_t            cth_reg   [COR_STAGES];
    cordic_t            cth_next  [COR_STAGES];
    sincos_t            scphi_reg, scphi_next;
    sincos_t            scth_reg, scth_next;
    logic signed [31:0] x29_reg, x29_next;
    logic signed [31:0] y29_reg, y29_next;
    logic signed [31:0] z29_reg, z29_next;
    logic signed [15:0] px_reg, px_next;
    logic signed [15:0] py_reg, py_next;
    logic signed [15:0] pz_reg, pz_next;
    logic signed [15:0] px2_reg, py2_reg, pz2_reg;
    logic [16:0]        shade_reg, shade_next;
    out_beat_t          out_reg, skid_reg;
    out_beat_t          fin;

    // clamp stage
    logic [CNT_W-1:0] i_lim, j_lim;

    always_comb
    begin
        i_lim   = (in_beat.req_type == REQ_QUAD) ? stacks_reg - 9'd1 : stacks_reg;
        j_lim   = (in_beat.req_type == REQ_QUAD) ? slices_reg - 9'd1 : slices_reg;
        i0_next = (in_beat.ring > i_lim) ? i_lim : in_beat.ring;
        j0_next = (in_beat.segment > j_lim) ? j_lim : in_beat.segment;
    end

    // dividend setup, quad base index, divider stages
    logic [33:0] dv_phi, dv_th;
    logic [18:0] a_full;

    always_comb
    begin
        dv_phi = (34'(i0_reg) << 23) + 34'(stacks_reg[CNT_W-1:1]);
        dv_th  = (34'(j0_reg) << 24) + 34'(slices_reg[CNT_W-1:1]);
        dphi_next[0].rem = dv_phi[33:QUOT_W];
        dphi_next[0].qd  = dv_phi[QUOT_W-1:0];
        dth_next[0].rem  = dv_th[33:QUOT_W];
        dth_next[0].qd   = dv_th[QUOT_W-1:0];
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            dphi_next[s+1] = div_stage(dphi_reg[s], stacks_reg);
            dth_next[s+1]  = div_stage(dth_reg[s], slices_reg);
        end
        a_full = 19'(i0_reg) * (19'(slices_reg) + 19'd1) + 19'(j0_reg);
    end

    // side data: a set at init, b one stage later
    always_comb
    begin
        side_next[0].req = in_beat.req_type;
        side_next[0].a   = '0;
        side_next[0].b   = '0;
        for (int s = 1; s < PIPE_DEPTH; s++)
            side_next[s] = side_reg[s-1];
        side_next[ST_INIT].a = a_full[IDX_W-1:0];
        side_next[ST_DIV0].b = side_reg[ST_INIT].a + 17'(slices_reg) + 17'd1;
    end

    // phase to first-quadrant angle
    logic [QUOT_W-2:0] ph_phi, ph_th;
    logic [51:0]       zp_phi, zp_th;

    always_comb
    begin
        ph_phi       = dphi_reg[DIV_STAGES].qd[QUOT_W-2:0];
        ph_th        = dth_reg[DIV_STAGES].qd[QUOT_W-2:0];
        zp_phi       = 52'(ph_phi[21:0]) * 52'(HALF_PI_Q29);
        zp_th        = 52'(ph_th[21:0]) * 52'(HALF_PI_Q29);
        zphi_next    = {2'b00, zp_phi[51:22]};
        zth_next     = {2'b00, zp_th[51:22]};
        qphi_next[0] = ph_phi[23:22];
        qth_next[0]  = ph_th[23:22];
        for (int s = 1; s <= COR_STAGES; s++)
        begin
            qphi_next[s] = qphi_reg[s-1];
            qth_next[s]  = qth_reg[s-1];
        end
    end

    // CORDIC rotation stages
    cordic_t cinit_phi, cinit_th;

    always_comb
    begin
        cinit_phi = '{x: CORDIC_GAIN, y: 32'sd0, z: zphi_reg};
        cinit_th  = '{x: CORDIC_GAIN, y: 32'sd0, z: zth_reg};
        cphi_next[0] = cordic_stage(cinit_phi, 0);
        cth_next[0]  = cordic_stage(cinit_th, 0);
        for (int s = 1; s < COR_STAGES; s++)
        begin
            cphi_next[s] = cordic_stage(cphi_reg[s-1], s);
            cth_next[s]  = cordic_stage(cth_reg[s-1], s);
        end
    end

    // quadrant map, products, Q2.14, shade
    logic signed [63:0] prod_x, prod_z;
    logic signed [16:0] u_s;
    logic [15:0]        u;
    logic [31:0]        shade_acc;

    always_comb
    begin
        scphi_next = map_quadrant(cphi_reg[COR_STAGES-1], qphi_reg[COR_STAGES]);
        scth_next  = map_quadrant(cth_reg[COR_STAGES-1], qth_reg[COR_STAGES]);

        prod_x   = scphi_reg.sin_v * scth_reg.cos_v;
        prod_z   = scphi_reg.sin_v * scth_reg.sin_v;
        prod_x   = (prod_x + 64'sd268435456) >>> 29;
        prod_z   = (prod_z + 64'sd268435456) >>> 29;
        x29_next = prod_x[31:0];
        z29_next = prod_z[31:0];
        y29_next = scphi_reg.cos_v;

        px_next = to_q14(x29_reg);
        py_next = to_q14(y29_reg);
        pz_next = to_q14(z29_reg);

        u_s        = 17'(py_reg) + 17'sd16384;
        u          = u_s[16] ? 16'd0 : u_s[15:0];
        shade_acc  = (SHADE_SPAN * 32'(u) + 32'd16384) >> 15;
        shade_next = SHADE_BASE + shade_acc[16:0];
    end

    // result assembly
    logic [33:0] red_acc, green_acc, blue_acc;
    side_t       last;

    always_comb
    begin
        last      = side_reg[PIPE_DEPTH-1];
        red_acc   = (RED_Q16 * 34'(shade_reg) + 34'd32768) >> 16;
        green_acc = (GREEN_Q16 * 34'(shade_reg) + 34'd32768) >> 16;
        blue_acc  = (BLUE_Q16 * 34'(shade_reg) + 34'd32768) >> 16;
        fin = '0;
        if (last.req == REQ_QUAD)
        begin
            fin.tri0_first  = last.a;
            fin.tri0_second = last.b;
            fin.tri0_third  = last.a + 17'd1;
            fin.tri1_first  = last.a + 17'd1;
            fin.tri1_second = last.b;
            fin.tri1_third  = last.b + 17'd1;
        end
        else
        begin
            fin.pos_x = px2_reg;
            fin.pos_y = py2_reg;
            fin.pos_z = pz2_reg;
            fin.red   = red_acc[15:0];
            fin.green = green_acc[15:0];
            fin.blue  = blue_acc[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            i0_reg <= i0_next;
            j0_reg <= j0_next;
            for (int s = 0; s < PIPE_DEPTH; s++)
                side_reg[s] <= side_next[s];
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                dphi_reg[s] <= dphi_next[s];
                dth_reg[s]  <= dth_next[s];
            end
            zphi_reg <= zphi_next;
            zth_reg  <= zth_next;
            for (int s = 0; s <= COR_STAGES; s++)
            begin
                qphi_reg[s] <= qphi_next[s];
                qth_reg[s]  <= qth_next[s];
            end
            for (int s = 0; s < COR_STAGES; s++)
            begin
                cphi_reg[s] <= cphi_next[s];
                cth_reg[s]  <= cth_next[s];
            end
            scphi_reg <= scphi_next;
            scth_reg  <= scth_next;
            x29_reg   <= x29_next;
            y29_reg   <= y29_next;
            z29_reg   <= z29_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            pz_reg    <= pz_next;
            px2_reg   <= px_reg;
            py2_reg   <= py_reg;
            pz2_reg   <= pz_reg;
            shade_reg <= shade_next;
        end
    end

    // output register with one-beat skid
    logic load_out_pipe, load_out_skid, load_skid;

    always_comb
    begin
        load_out_skid   = skid_valid_reg && !out_stall;
        load_out_pipe   = !skid_valid_reg && vld_reg[PIPE_DEPTH-1]
                          && (!out_valid_reg || !out_stall);
        load_skid       = !skid_valid_reg && vld_reg[PIPE_DEPTH-1]
                          && out_valid_reg && out_stall;
        skid_valid_next = skid_valid_reg;
        out_valid_next  = out_valid_reg;
        if (load_out_skid)
            skid_valid_next = 1'b0;
        else if (load_skid)
            skid_valid_next = 1'b1;
        if (load_out_pipe)
            out_valid_next = 1'b1;
        else if (!skid_valid_reg && !vld_reg[PIPE_DEPTH-1] && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_skid)
            out_reg <= skid_reg;
        else if (load_out_pipe)
            out_reg <= fin;
        if (load_skid)
            skid_reg <= fin;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the UV-sphere mesh generator: vertex and quad beats against a predictor.
`timescale 1ns / 1ps

module tb;
    import uvs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;
    localparam int unsigned PIPE_LAT = 24;
    localparam int unsigned PER_PHASE = 130;

    typedef logic [16:0] field_vec_t [12];

    typedef struct {
        in_beat_t  beat;
        bit        typed;
        out_beat_t want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    in_beat_t           in_beat;
    logic               out_valid;
    logic               out_stall;
    out_beat_t          out_beat;

    out_beat_t   mesh_q[$];
    logic [8:0]  stacks_reg;
    logic [8:0]  slices_reg;
    int          send_gap_pct;
    int          recv_gap_pct;
    int          hold_cycles;
    int          mismatches;

    const longint arctan_tbl [24] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
        8387925, 4194219, 2097141, 1048575, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64
    };

    const string field_names [12] = '{
        "pos_x", "pos_y", "pos_z", "red", "green", "blue",
        "tri0_first", "tri0_second", "tri0_third", "tri1_first", "tri1_second", "tri1_third"
    };

    uv_sphere_mesh_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned count_in_use(input logic [8:0] raw);
        if (raw == 0)
            return 1;
        return (raw > 256) ? 256 : 32'(raw);
    endfunction

    // cos/sin in Q2.29 of a phase in 2^-24 turns
    function automatic void turn_sincos(input logic [23:0] ph, output longint c, output longint s);
        longint unsigned r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        r = ph[21:0];
        z = longint'((r * 64'd843314857) >> 22);
        x = 326016435;
        y = 0;
        for (int k = 0; k < 24; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_tbl[k];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_tbl[k];
            end
        end
        case (ph[23:22])
            2'd0:
            begin
                c = x;
                s = y;
            end
            2'd1:
            begin
                c = -y;
                s = x;
            end
            2'd2:
            begin
                c = -x;
                s = -y;
            end
            default:
            begin
                c = y;
                s = -x;
            end
        endcase
    endfunction

    function automatic longint sat_q14(input longint v29);
        longint v;
        v = (v29 + 16384) >>> 15;
        if (v > 16384)
            v = 16384;
        if (v < -16384)
            v = -16384;
        return v;
    endfunction

    function automatic longint mul_round_q29(input longint a, input longint b);
        return (a * b + (longint'(1) << 28)) >>> 29;
    endfunction

    function automatic out_beat_t mesh_point(input in_beat_t b);
        out_beat_t       r;
        longint unsigned st;
        longint unsigned sl;
        longint unsigned i;
        longint unsigned j;
        longint unsigned a;
        longint unsigned bb;
        longint unsigned shade;
        longint unsigned ph_phi;
        longint unsigned ph_th;
        longint          cphi;
        longint          sphi;
        longint          cth;
        longint          sth;
        longint          py;
        longint          u;
        r  = '0;
        st = count_in_use(stacks_reg);
        sl = count_in_use(slices_reg);
        i  = b.ring;
        j  = b.segment;
        if (b.req_type == REQ_QUAD)
        begin
            if (i > st - 1)
                i = st - 1;
            if (j > sl - 1)
                j = sl - 1;
            a  = i * (sl + 1) + j;
            bb = a + sl + 1;
            r.tri0_first  = a[16:0];
            r.tri0_second = bb[16:0];
            r.tri0_third  = 17'(a + 1);
            r.tri1_first  = 17'(a + 1);
            r.tri1_second = bb[16:0];
            r.tri1_third  = 17'(bb + 1);
            return r;
        end
        if (i > st)
            i = st;
        if (j > sl)
            j = sl;
        ph_phi = ((i << 23) + st / 2) / st;
        ph_th  = ((j << 24) + sl / 2) / sl;
        turn_sincos(ph_phi[23:0], cphi, sphi);
        turn_sincos(ph_th[23:0], cth, sth);
        py = sat_q14(cphi);
        r.pos_x = 16'(sat_q14(mul_round_q29(sphi, cth)));
        r.pos_y = 16'(py);
        r.pos_z = 16'(sat_q14(mul_round_q29(sphi, sth)));
        u = py + 16384;
        if (u < 0)
            u = 0;
        shade   = 39322 + ((26214 * longint'(u) + 16384) >> 15);
        r.red   = 16'((19661 * shade + 32768) >> 16);
        r.green = 16'((36045 * shade + 32768) >> 16);
        r.blue  = 16'((55706 * shade + 32768) >> 16);
        return r;
    endfunction

    function automatic field_vec_t split_fields(input out_beat_t o);
        field_vec_t f;
        f = '{17'(o.pos_x), 17'(o.pos_y), 17'(o.pos_z), 17'(o.red), 17'(o.green), 17'(o.blue),
              o.tri0_first, o.tri0_second, o.tri0_third,
              o.tri1_first, o.tri1_second, o.tri1_third};
        return f;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        out_beat_t  want;
        field_vec_t fw;
        field_vec_t fg;
        bit         bad;
        if (rst_n && out_valid && !out_stall)
        begin
            if (mesh_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat at %0t", $realtime);
            end
            else
            begin
                want = mesh_q.pop_front();
                fw   = split_fields(want);
                fg   = split_fields(out_beat);
                bad  = 1'b0;
                for (int k = 0; k < 12; k++)
                begin
                    if (fg[k] !== fw[k])
                    begin
                        bad = 1'b1;
                        if (mismatches < 10)
                            $display("mismatch %s: expected %0h got %0h at %0t",
                                     field_names[k], fw[k], fg[k], $realtime);
                    end
                end
                if (bad)
                    mismatches++;
            end
        end
    end

    // receiver stall generator
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else
                out_stall = ($urandom_range(0, 99) < recv_gap_pct);
        end
    end

    task automatic send_request(input in_beat_t b, input bit typed, input out_beat_t want);
        bit taken;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_beat  = b;
        taken    = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !in_stall;
            if (taken)
                mesh_q.insert(mesh_q.size(), typed ? want : mesh_point(b));
            @(negedge clk);
        end
        in_valid = 1'b0;
    endtask

    task automatic drain_mesh();
        while (mesh_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 6) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (idx == CFG_STACKS)
            stacks_reg = val;
        else if (idx == CFG_SLICES)
            slices_reg = val;
    endtask

    function automatic in_beat_t random_request();
        in_beat_t b;
        int unsigned st;
        int unsigned sl;
        st = count_in_use(stacks_reg);
        sl = count_in_use(slices_reg);
        b.req_type = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 80)
        begin
            b.ring    = 9'($urandom_range(0, st + 1));
            b.segment = 9'($urandom_range(0, sl + 1));
        end
        else
        begin
            b.ring    = 9'($urandom_range(0, 511));
            b.segment = 9'($urandom_range(0, 511));
        end
        return b;
    endfunction

    function automatic out_beat_t quad_ids(input int a, input int b);
        out_beat_t r;
        r = '0;
        r.tri0_first  = 17'(a);
        r.tri0_second = 17'(b);
        r.tri0_third  = 17'(a + 1);
        r.tri1_first  = 17'(a + 1);
        r.tri1_second = 17'(b);
        r.tri1_third  = 17'(b + 1);
        return r;
    endfunction

    initial
    begin
        dir_row_t  rows [$];
        out_beat_t none;
        logic [8:0] stk_set [6];
        logic [8:0] slc_set [6];
        none = '0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_STACKS;
        cfg_data = '0;
        in_valid = 1'b0;
        in_beat = '0;
        stacks_reg = 9'd16;
        slices_reg = 9'd32;
        send_gap_pct = 14;
        recv_gap_pct = 71;
        hold_cycles = 0;
        mismatches = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset counts: 16 stacks, 32 slices
        // north pole, then south pole
        rows.insert(rows.size(), '{'{REQ_VERTEX, 9'd0, 9'd0}, 1'b0, none});
        rows.insert(rows.size(), '{'{REQ_VERTEX, 9'd16, 9'd0}, 1'b0, none});
        rows.insert(rows.size(), '{'{REQ_VERTEX, 9'd8, 9'd8}, 1'b0, none});
        rows.insert(rows.size(), '{'{REQ_VERTEX, 9'd8, 9'd16}, 1'b0, none});
        rows.insert(rows.size(), '{'{REQ_VERTEX, 9'd8, 9'd24}, 1'b0, none});
        rows.insert(rows.size(), '{'{REQ_VERTEX, 9'd4, 9'd3}, 1'b0, none});
        // seam wraps
        rows.insert(rows.size(), '{'{REQ_VERTEX, 9'd12, 9'd32}, 1'b0, none});
        // clamp to count
        rows.insert(rows.size(), '{'{REQ_VERTEX, 9'd511, 9'd511}, 1'b0, none});
        rows.insert(rows.size(), '{'{REQ_VERTEX, 9'd256, 9'd256}, 1'b0, none});
        rows.insert(rows.size(), '{'{REQ_QUAD, 9'd0, 9'd0}, 1'b1, quad_ids(0, 33)});
        rows.insert(rows.size(), '{'{REQ_QUAD, 9'd7, 9'd5}, 1'b1, quad_ids(236, 269)});
        rows.insert(rows.size(), '{'{REQ_QUAD, 9'd0, 9'd31}, 1'b1, quad_ids(31, 64)});
        rows.insert(rows.size(), '{'{REQ_QUAD, 9'd15, 9'd31}, 1'b1, quad_ids(526, 559)});
        // clamp to count-1
        rows.insert(rows.size(), '{'{REQ_QUAD, 9'd511, 9'd511}, 1'b1, quad_ids(526, 559)});
        rows.insert(rows.size(), '{'{REQ_QUAD, 9'd256, 9'd0}, 1'b1, quad_ids(495, 528)});
        rows.insert(rows.size(), '{'{REQ_QUAD, 9'd16, 9'd32}, 1'b1, quad_ids(526, 559)});
        foreach (rows[n])
            send_request(rows[n].beat, rows[n].typed, rows[n].want);
        drain_mesh();

        // writes to unused indexes must not disturb the counts
        write_reg(CFG_SPARE2, 9'h1FF);
        write_reg(CFG_SPARE3, 9'h0AA);
        send_request('{REQ_QUAD, 9'd1, 9'd1}, 1'b1, quad_ids(34, 67));
        drain_mesh();

        stk_set = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd2, 9'($urandom_range(1, 256))};
        slc_set = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd3, 9'($urandom_range(1, 256))};
        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_gap_pct = 14;
                recv_gap_pct = 71;
            end
            else if (p < 4)
            begin
                send_gap_pct = 71;
                recv_gap_pct = 14;
            end
            else
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            write_reg(CFG_STACKS, stk_set[p]);
            write_reg(CFG_SLICES, slc_set[p]);
            // long receiver hold so the pipe backs up into the input
            if (p == 4)
                hold_cycles = 80;
            for (int n = 0; n < PER_PHASE; n++)
                send_request(random_request(), 1'b0, none);
            drain_mesh();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
src/uvs_pkg.sv
src/uv_sphere_mesh_generator.sv
tb/tb.sv
